FILE: rtl/tpa_pkg.sv
// shared types and fixed field widths for the triangle perimeter/area block
// no dependencies
`default_nettype none

package tpa_pkg;

    // widths of the result fields
    localparam int PERIM_W = 22;
    localparam int AREA_W  = 25;

    // pipeline control shared by every stage
    typedef struct packed {
        logic adv;
    } ctl_t;

endpackage

`default_nettype wire

FILE: rtl/tpa_sqrt.sv
// pipelined integer square root, one root bit per register stage, one or more lanes
// depends on tpa_pkg
`default_nettype none

module tpa_sqrt #(
    parameter int LANES = 1,
    parameter int RW    = 8
) (
    input  wire logic            clk,
    input  wire tpa_pkg::ctl_t   ctl,
    input  wire logic [RW-1:0]   rad [LANES],
    output logic [RW/2-1:0]      root [LANES]
);
    import tpa_pkg::*;

    localparam int NS = RW / 2;
    localparam int QW = RW / 2;
    localparam int MW = QW + 2;

    logic [RW-1:0] rad_reg  [NS][LANES];
    logic [MW-1:0] rem_reg  [NS][LANES];
    logic [QW-1:0] root_reg [NS][LANES];

    genvar s, l;
    generate
        for (s = 0; s < NS; s++) begin : g_stage
            for (l = 0; l < LANES; l++) begin : g_lane
                logic [RW-1:0] rad_in;
                logic [MW-1:0] rem_in;
                logic [QW-1:0] root_in;
                logic [MW-1:0] cur;
                logic [MW-1:0] trial;

                // stage inputs
                if (s == 0) begin : g_first
                    assign rad_in  = rad[l];
                    assign rem_in  = '0;
                    assign root_in = '0;
                end
                else begin : g_next
                    assign rad_in  = rad_reg[s-1][l];
                    assign rem_in  = rem_reg[s-1][l];
                    assign root_in = root_reg[s-1][l];
                end

                // bring down two radicand bits and try the next root bit
                assign cur   = {rem_in[MW-3:0], rad_in[RW-1 -: 2]};
                assign trial = {root_in, 2'b01};

                always_ff @(posedge clk)
                begin
                    if (ctl.adv)
                    begin
                        rad_reg[s][l] <= {rad_in[RW-3:0], 2'b00};
                        if (cur >= trial)
                        begin
                            rem_reg[s][l]  <= cur - trial;
                            root_reg[s][l] <= {root_in[QW-2:0], 1'b1};
                        end
                        else
                        begin
                            rem_reg[s][l]  <= cur;
                            root_reg[s][l] <= {root_in[QW-2:0], 1'b0};
                        end
                    end
                end
            end
        end

        // final roots
        for (l = 0; l < LANES; l++) begin : g_out
            assign root[l] = root_reg[NS-1][l];
        end
    endgenerate

endmodule

`default_nettype wire

FILE: rtl/tpa_delay.sv
// shift register that carries valid bits or side data alongside a pipeline
// depends on tpa_pkg
`default_nettype none

module tpa_delay #(
    parameter int W = 1,
    parameter int D = 1
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire tpa_pkg::ctl_t ctl,
    input  wire logic [W-1:0]  din,
    output logic [W-1:0]       dout
);
    import tpa_pkg::*;

    logic [W-1:0] tap_reg [D];

    // shift on each advance
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < D; i++)
            begin
                tap_reg[i] <= '0;
            end
        end
        else if (ctl.adv)
        begin
            tap_reg[0] <= din;
            for (int i = 1; i < D; i++)
            begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign dout = tap_reg[D-1];

endmodule

`default_nettype wire

FILE: rtl/triangle_perimeter_area_top.sv
// triangle perimeter and Heron area, fully pipelined
// its depth is set mostly by the two bit-per-stage square root pipelines;
// throughput one request per cycle while the output register is free or taken
// the whole pipeline holds while the output register is full and not taken
// reset clears all valid bits and the perimeter delay line, no other data
`default_nettype none

module triangle_perimeter_area_top #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 8
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic signed [COORD_BITS-1:0] ax,
    input  wire logic signed [COORD_BITS-1:0] ay,
    input  wire logic signed [COORD_BITS-1:0] bx,
    input  wire logic signed [COORD_BITS-1:0] by_coord,
    input  wire logic signed [COORD_BITS-1:0] cx,
    input  wire logic signed [COORD_BITS-1:0] cy,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [tpa_pkg::PERIM_W-1:0]       perimeter_q8,
    output logic [tpa_pkg::AREA_W-1:0]        area_q2
);
    import tpa_pkg::*;

    localparam int AW     = COORD_BITS;
    localparam int SQW    = 2 * COORD_BITS + 1;
    localparam int RADW0  = SQW + 2 * FRAC_BITS;
    localparam int RADW   = RADW0 + (RADW0 % 2);
    localparam int SW     = RADW / 2;
    localparam int PW     = SW + 2;
    localparam int PRODW  = 4 * PW;
    localparam int ROOTW  = 2 * PW;
    localparam int AFW    = ROOTW - 2 * FRAC_BITS;
    localparam int AEW    = (AFW > AREA_W) ? AFW : AREA_W;
    localparam int PEW    = (PW > PERIM_W) ? PW : PERIM_W;
    localparam int VDEPTH = SW + ROOTW + 7;

    ctl_t ctl;
    logic out_valid_reg;

    // global advance: move when the output slot is free or being taken
    assign ctl.adv  = out_ready || !out_valid_reg;
    assign in_ready = ctl.adv;

    // stage 1: absolute coordinate differences per side
    logic [AW-1:0] ux_reg [3];
    logic [AW-1:0] uy_reg [3];

    function automatic logic [AW-1:0] abs_diff(input logic signed [AW-1:0] p,
                                               input logic signed [AW-1:0] q);
        logic signed [AW:0] d;
        d = {p[AW-1], p} - {q[AW-1], q};
        abs_diff = d[AW] ? AW'(-d) : d[AW-1:0];
    endfunction

    always_ff @(posedge clk)
    begin
        if (ctl.adv)
        begin
            ux_reg[0] <= abs_diff(ax, bx);
            uy_reg[0] <= abs_diff(ay, by_coord);
            ux_reg[1] <= abs_diff(bx, cx);
            uy_reg[1] <= abs_diff(by_coord, cy);
            ux_reg[2] <= abs_diff(cx, ax);
            uy_reg[2] <= abs_diff(cy, ay);
        end
    end

    // stage 2: squared lengths scaled for the fraction bits
    logic [RADW-1:0] rad_reg [3];

    always_ff @(posedge clk)
    begin
        if (ctl.adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                rad_reg[i] <= RADW'(SQW'(ux_reg[i] * ux_reg[i]) + SQW'(uy_reg[i] * uy_reg[i]))
                              << (2 * FRAC_BITS);
            end
        end
    end

    // side lengths
    logic [SW-1:0] side [3];

    tpa_sqrt #(
        .LANES (3),
        .RW    (RADW)
    ) u_side_sqrt (
        .clk  (clk),
        .ctl  (ctl),
        .rad  (rad_reg),
        .root (side)
    );

    // stage 3: perimeter, sides kept
    logic [PW-1:0] p3_reg;
    logic [SW-1:0] side3_reg [3];

    always_ff @(posedge clk)
    begin
        if (ctl.adv)
        begin
            p3_reg <= PW'(side[0]) + PW'(side[1]) + PW'(side[2]);
            for (int i = 0; i < 3; i++)
            begin
                side3_reg[i] <= side[i];
            end
        end
    end

    // stage 4: heron terms, clamped at zero
    logic [PW-1:0] p4_reg;
    logic [PW-1:0] term_reg [3];

    always_ff @(posedge clk)
    begin
        if (ctl.adv)
        begin
            p4_reg <= p3_reg;
            for (int i = 0; i < 3; i++)
            begin
                if (PW'({side3_reg[i], 1'b0}) >= p3_reg)
                begin
                    term_reg[i] <= '0;
                end
                else
                begin
                    term_reg[i] <= p3_reg - PW'({side3_reg[i], 1'b0});
                end
            end
        end
    end

    // stage 5: two pair products
    logic [PW-1:0]   p5_reg;
    logic [2*PW-1:0] m1_reg;
    logic [2*PW-1:0] m2_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.adv)
        begin
            p5_reg <= p4_reg;
            m1_reg <= p4_reg * term_reg[0];
            m2_reg <= term_reg[1] * term_reg[2];
        end
    end

    // stage 6: partial products of the wide multiply
    logic [PW-1:0]   p6_reg;
    logic [2*PW-1:0] pp_ll_reg, pp_lh_reg, pp_hl_reg, pp_hh_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.adv)
        begin
            p6_reg    <= p5_reg;
            pp_ll_reg <= m1_reg[PW-1:0]      * m2_reg[PW-1:0];
            pp_lh_reg <= m1_reg[PW-1:0]      * m2_reg[2*PW-1:PW];
            pp_hl_reg <= m1_reg[2*PW-1:PW]   * m2_reg[PW-1:0];
            pp_hh_reg <= m1_reg[2*PW-1:PW]   * m2_reg[2*PW-1:PW];
        end
    end

    // stage 7: full heron product
    logic [PW-1:0]    p7_reg;
    logic [PRODW-1:0] prod_reg [1];

    always_ff @(posedge clk)
    begin
        if (ctl.adv)
        begin
            p7_reg      <= p6_reg;
            prod_reg[0] <= (PRODW'(pp_hh_reg) << (2 * PW))
                         + (PRODW'(pp_lh_reg) << PW)
                         + (PRODW'(pp_hl_reg) << PW)
                         + PRODW'(pp_ll_reg);
        end
    end

    // area root, perimeter rides alongside
    logic [ROOTW-1:0] root [1];
    logic [PW-1:0]    p_late;

    tpa_sqrt #(
        .LANES (1),
        .RW    (PRODW)
    ) u_area_sqrt (
        .clk  (clk),
        .ctl  (ctl),
        .rad  (prod_reg),
        .root (root)
    );

    tpa_delay #(
        .W (PW),
        .D (ROOTW)
    ) u_perim_dly (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .din   (p7_reg),
        .dout  (p_late)
    );

    // valid bits follow the data
    logic v_late;

    tpa_delay #(
        .W (1),
        .D (VDEPTH)
    ) u_valid_dly (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .din   (in_valid),
        .dout  (v_late)
    );

    // output stage with saturation
    logic [AEW-1:0] area_ext;
    logic [PEW-1:0] perim_ext;
    logic [PERIM_W-1:0] perim_reg;
    logic [AREA_W-1:0]  area_reg;

    assign area_ext  = AEW'(root[0][ROOTW-1:2*FRAC_BITS]);
    assign perim_ext = PEW'(p_late);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl.adv)
        begin
            out_valid_reg <= v_late;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.adv)
        begin
            if (perim_ext > PEW'({PERIM_W{1'b1}}))
            begin
                perim_reg <= '1;
            end
            else
            begin
                perim_reg <= perim_ext[PERIM_W-1:0];
            end
            if (area_ext > AEW'({AREA_W{1'b1}}))
            begin
                area_reg <= '1;
            end
            else
            begin
                area_reg <= area_ext[AREA_W-1:0];
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign perimeter_q8 = perim_reg;
    assign area_q2      = area_reg;

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
// testbench for triangle_perimeter_area_top: directed and random triangles,
// results predicted in fixed point by an independent model and checked in order
// depends on rtl/tpa_pkg.sv and rtl/triangle_perimeter_area_top.sv
`default_nettype none

module tb;

    import tpa_pkg::*;

    localparam int CB        = 12;
    localparam int FB        = 8;
    localparam int IDLE_MAX  = 11;
    localparam int DOG_LIMIT = 3000;
    localparam int TAIL_WAIT = 120;

    typedef logic signed [CB-1:0] coord_t;

    typedef struct {
        logic [PERIM_W-1:0] perim;
        logic [AREA_W-1:0]  area;
    } tri_meas_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    coord_t ax, ay, bx, by_coord, cx, cy;
    logic out_valid;
    logic out_ready;
    logic [PERIM_W-1:0] perimeter_q8;
    logic [AREA_W-1:0]  area_q2;

    tri_meas_t pending_meas[$];
    int errors;
    int sent;
    int checked;
    int zero_areas;
    int quiet_cycles;
    bit no_idle;

    triangle_perimeter_area_top #(
        .COORD_BITS(CB),
        .FRAC_BITS (FB)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .ax          (ax),
        .ay          (ay),
        .bx          (bx),
        .by_coord    (by_coord),
        .cx          (cx),
        .cy          (cy),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .perimeter_q8(perimeter_q8),
        .area_q2     (area_q2)
    );

    // clock
    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // floor of the square root, bit by bit
    function automatic logic [63:0] floor_sqrt(input logic [127:0] n);
        logic [63:0]  r;
        logic [127:0] c;
        r = '0;
        for (int b = 63; b >= 0; b--)
        begin
            c = {64'd0, r | (64'd1 << b)};
            if (c * c <= n)
                r = c[63:0];
        end
        return r;
    endfunction

    // side length with FB fraction bits
    function automatic logic [63:0] side_q8(input coord_t x0, input coord_t y0,
                                            input coord_t x1, input coord_t y1);
        longint dx, dy;
        logic [127:0] sq;
        dx = longint'(x0) - longint'(x1);
        dy = longint'(y0) - longint'(y1);
        if (dx < 0)
            dx = -dx;
        if (dy < 0)
            dy = -dy;
        sq = 128'(dx * dx + dy * dy) << (2 * FB);
        return floor_sqrt(sq);
    endfunction

    // s minus twice a side, clamped at zero
    function automatic logic [63:0] heron_gap(input logic [63:0] s, input logic [63:0] side);
        logic [63:0] twice;
        twice = side << 1;
        return (twice >= s) ? 64'd0 : s - twice;
    endfunction

    // expected perimeter and area of one triangle
    function automatic tri_meas_t heron_predict(input coord_t x0, input coord_t y0,
                                                input coord_t x1, input coord_t y1,
                                                input coord_t x2, input coord_t y2);
        logic [63:0]  sa, sb, sc, p;
        logic [127:0] prod, area;
        tri_meas_t    m;
        sa = side_q8(x0, y0, x1, y1);
        sb = side_q8(x1, y1, x2, y2);
        sc = side_q8(x2, y2, x0, y0);
        p = sa + sb + sc;
        // semiperimeter with one more fraction bit is numerically p
        prod = (128'(p) * 128'(heron_gap(p, sa)))
             * (128'(heron_gap(p, sb)) * 128'(heron_gap(p, sc)));
        area = 128'(floor_sqrt(prod)) >> (2 * FB);
        m.perim = (p > 64'((1 << PERIM_W) - 1)) ? '1 : p[PERIM_W-1:0];
        m.area  = (area > 128'((1 << AREA_W) - 1)) ? '1 : area[AREA_W-1:0];
        return m;
    endfunction

    task automatic report_mismatch(input string what, input longint want, input longint got);
        $display("mismatch on result %0d: %s expected %0d got %0d", checked, what, want, got);
        errors++;
    endtask

    // one triangle request
    task automatic send_tri(input coord_t x0, input coord_t y0, input coord_t x1,
                            input coord_t y1, input coord_t x2, input coord_t y2);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, IDLE_MAX);
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        ax       <= x0;
        ay       <= y0;
        bx       <= x1;
        by_coord <= y1;
        cx       <= x2;
        cy       <= y2;
        do
            @(posedge clk);
        while (!in_ready);
        pending_meas.push_back(heron_predict(x0, y0, x1, y1, x2, y2));
        sent++;
    endtask

    task automatic hold_until_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        wait (pending_meas.size() == 0);
    endtask

    function automatic coord_t any_coord();
        return coord_t'($urandom_range(0, (1 << CB) - 1));
    endfunction

    // directed corners and special cases
    task automatic test_directed();
        coord_t lo, hi;
        lo = coord_t'(-2048);
        hi = coord_t'(2047);
        send_tri(0, 0, 0, 0, 0, 0);
        send_tri(lo, lo, lo, lo, lo, lo);
        send_tri(lo, lo, hi, lo, lo, hi);
        send_tri(lo, lo, hi, hi, lo, hi);
        send_tri(hi, hi, lo, lo, hi, lo);
        send_tri(lo, hi, hi, lo, hi, hi);
        send_tri(lo, lo, hi, hi, 0, 0);
        send_tri(lo, 0, hi, 0, 5, 0);
        send_tri(0, 0, 3, 0, 0, 4);
        send_tri(1, 1, 1, 1, 7, -3);
        send_tri(0, 0, 1, 0, 0, 1);
        send_tri(0, 0, 1, 0, 2, 1);
        send_tri(0, 0, 2047, 1, -2048, -1);
        send_tri(-1, -1, -1, 0, 0, -1);
        send_tri(lo, hi, 0, 0, hi, lo);
        send_tri(100, -200, 300, 400, -500, 600);
    endtask

    // full-range, small, collinear and coincident triangles
    task automatic test_random(input int count);
        int kind, bx0, by0, dx, dy;
        coord_t p[6];
        for (int i = 0; i < count; i++)
        begin
            kind = $urandom_range(0, 9);
            if (i % 300 == 0)
                no_idle = ($urandom_range(0, 1) == 1);
            if (kind < 5)
            begin
                foreach (p[j])
                    p[j] = any_coord();
            end
            else if (kind < 7)
            begin
                foreach (p[j])
                    p[j] = coord_t'($urandom_range(0, 16) - 8);
            end
            else if (kind < 9)
            begin
                bx0 = $urandom_range(0, 1000) - 500;
                by0 = $urandom_range(0, 1000) - 500;
                dx  = $urandom_range(0, 40) - 20;
                dy  = $urandom_range(0, 40) - 20;
                for (int j = 0; j < 3; j++)
                begin
                    int k;
                    k = $urandom_range(0, 100) - 50;
                    p[2*j]   = coord_t'(bx0 + k * dx);
                    p[2*j+1] = coord_t'(by0 + k * dy);
                end
            end
            else
            begin
                p[0] = any_coord();
                p[1] = any_coord();
                p[2] = p[0];
                p[3] = p[1];
                p[4] = any_coord();
                p[5] = any_coord();
            end
            send_tri(p[0], p[1], p[2], p[3], p[4], p[5]);
        end
        no_idle = 1'b0;
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_meas.size() == 0)
            begin
                $display("result with no request outstanding: perimeter %0d area %0d",
                         perimeter_q8, area_q2);
                errors++;
            end
            else
            begin
                tri_meas_t m;
                m = pending_meas.pop_front();
                if (perimeter_q8 !== m.perim)
                    report_mismatch("perimeter", m.perim, perimeter_q8);
                if (area_q2 !== m.area)
                    report_mismatch("area", m.area, area_q2);
                if (m.area == 0)
                    zero_areas++;
            end
            checked++;
        end
    end

    // receiver back-pressure
    initial
    begin
        int stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, IDLE_MAX);
            repeat (stall)
            begin
                @(negedge clk);
                out_ready <= 1'b0;
            end
            @(negedge clk);
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!(out_valid && out_ready));
        end
    end

    // watchdog on cycles with no handshake
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= DOG_LIMIT)
        begin
            $display("timeout with %0d results outstanding", pending_meas.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        errors       = 0;
        sent         = 0;
        checked      = 0;
        zero_areas   = 0;
        quiet_cycles = 0;
        no_idle      = 1'b0;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        ax           = '0;
        ay           = '0;
        bx           = '0;
        by_coord     = '0;
        cx           = '0;
        cy           = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        hold_until_drained();
        test_random(1850);

        @(negedge clk);
        in_valid <= 1'b0;
        wait (pending_meas.size() == 0);
        repeat (TAIL_WAIT) @(posedge clk);

        $display("covered %0d triangles, %0d results checked, %0d with zero area",
                 sent, checked, zero_areas);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire

FILE: filelist.f
rtl/tpa_pkg.sv
rtl/tpa_sqrt.sv
rtl/tpa_delay.sv
rtl/triangle_perimeter_area_top.sv
tb/sv/tb.sv
